// ----- sv/lzrd_pkg.sv -----
// lzrd_pkg: shared types and constants of the lzss ring decompressor
// used by lzss_ring_decompressor_core; no dependencies
`default_nettype none

package lzrd_pkg;

    // history ring geometry and restart values
    localparam int unsigned RING_AW    = 12;
    localparam int unsigned RING_DEPTH = 4096;
    localparam logic [RING_AW-1:0] START_POS = 12'd4078;
    localparam logic [RING_AW:0]   FILL_FULL = 13'd4096;
    localparam logic [7:0]         SPACE_BYTE = 8'h20;

    // command carried on the input side
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // status codes of a status word
    typedef enum logic [1:0] {
        ST_RUN      = 2'd0,
        ST_OK       = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // stream parsing phase
    typedef enum logic [2:0] {
        PH_FLAG  = 3'd0,
        PH_TOKEN = 3'd1,
        PH_MLO   = 3'd2,
        PH_MHI   = 3'd3,
        PH_CHECK = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    // control sequencer
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_LIT  = 2'd1,
        S_RD   = 2'd2,
        S_CPY  = 2'd3
    } fsm_t;

    // where a copied byte comes from
    typedef enum logic [1:0] {
        SEL_RAM   = 2'd0,
        SEL_FWD   = 2'd1,
        SEL_SPACE = 2'd2
    } sel_t;

    // an entry has been written since start when its distance from the
    // start position lies below the fill count
    function automatic logic entry_written(input logic [RING_AW-1:0] addr,
                                           input logic [RING_AW:0]   fill);
        logic [RING_AW-1:0] ofs;
        ofs = addr - START_POS;
        return (fill == FILL_FULL) || ({1'b0, ofs} < fill);
    endfunction

endpackage

`default_nettype wire

// ----- sv/lzss_ring_decompressor_core.sv -----
// lzss_ring_decompressor_core: lzss decoder over a 4096-byte history ring
// depends on lzrd_pkg and lzrd_ram
//
// Usage:
//   Input words carry a command in s_axis_tuser (0 start, 1 compressed byte)
//   and the compressed byte in s_axis_tdata. A start restarts the stream,
//   loads the byte count from the out_length register (cfg_wr_en/cfg_wr_data)
//   and makes the whole history read as spaces.
//   Output words carry a decompressed byte or a status code; m_axis_tuser is
//   1 for data, tlast marks the last word caused by one input word.
//   Sequencing: a start, flag byte, first match byte or checksum byte is
//   taken in S_IDLE; a literal, or the status of a final checksum byte or
//   overflow, goes out from S_LIT; a match of L bytes (3 to 18) passes S_RD
//   and S_CPY with one ring read per output byte. The next input word is
//   taken only once back in S_IDLE. Output words come from an output register.
//   The history ring has no clearing pass: a fill count since the last start
//   marks which entries read as spaces.
//   Reset acts as a start with out_length = 1. When the receiver stalls the
//   copy waits with its byte held and the input side stays not ready.
`default_nettype none

module lzss_ring_decompressor_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: out_length
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tuser,   // [0] command
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] status, rest 0
    output logic             m_axis_tuser,   // [0] is_data
    output logic             m_axis_tlast    // last
);

    localparam int unsigned AW = lzrd_pkg::RING_AW;

    // state registers
    lzrd_pkg::fsm_t    state_reg, state_next;
    lzrd_pkg::phase_t  phase_reg, phase_next;
    lzrd_pkg::sel_t    sel_reg, sel_next;
    logic [31:0]       out_length_reg;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW:0]       fill_reg, fill_next;
    logic [8:0]        flags_reg, flags_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       sum_reg, sum_next;
    logic [7:0]        offlo_reg, offlo_next;
    logic [31:0]       chk_reg, chk_next;
    logic [1:0]        chkcnt_reg, chkcnt_next;
    logic [7:0]        lit_reg, lit_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [4:0]        len_reg, len_next;
    logic [7:0]        fwd_byte_reg, fwd_byte_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic              m_isdata_reg, m_isdata_next;
    logic              m_last_reg, m_last_next;

    // ring ports
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    // working signals
    logic              in_fire, slot_free;
    logic              do_byte, do_status, emit_last;
    logic [7:0]        byte_val;
    logic [1:0]        status_val;
    logic [7:0]        copy_byte;
    logic [31:0]       rem_dec;
    logic [8:0]        flags_shr;
    lzrd_pkg::phase_t  phase_after;
    logic [AW-1:0]     match_dist, src_first, src_inc;
    logic [4:0]        match_len;
    logic [31:0]       chk_upd;
    logic [1:0]        chkcnt_inc;

    lzrd_ram #(
        .WIDTH (8),
        .DEPTH (lzrd_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (byte_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_length_reg <= 32'd1;
        end
        else if (cfg_wr_en)
        begin
            out_length_reg <= cfg_wr_data;
        end
    end

    // shared helpers
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign slot_free  = !m_valid_reg || m_axis_tready;
    assign rem_dec    = rem_reg - 32'd1;
    assign flags_shr  = flags_reg >> 1;
    assign match_dist = {s_axis_tdata[7:4], offlo_reg};
    assign match_len  = {1'b0, s_axis_tdata[3:0]} + 5'd3;
    assign src_first  = wp_reg - match_dist;
    assign src_inc    = src_reg + AW'(1);
    assign chk_upd    = chk_reg | ({24'd0, s_axis_tdata} << {chkcnt_reg, 3'b000});
    assign chkcnt_inc = chkcnt_reg + 2'd1;

    // byte of the current copy step
    always_comb
    begin
        case (sel_reg)
            lzrd_pkg::SEL_FWD:   copy_byte = fwd_byte_reg;
            lzrd_pkg::SEL_SPACE: copy_byte = lzrd_pkg::SPACE_BYTE;
            default:             copy_byte = ram_rdata;
        endcase
    end

    // phase after a token once the last byte of it has gone out
    always_comb
    begin
        if (rem_dec == 32'd0)
        begin
            phase_after = lzrd_pkg::PH_CHECK;
        end
        else if (flags_shr[8:1] == 8'd0)
        begin
            phase_after = lzrd_pkg::PH_FLAG;
        end
        else
        begin
            phase_after = lzrd_pkg::PH_TOKEN;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lzrd_pkg::S_IDLE;
            phase_reg    <= lzrd_pkg::PH_FLAG;
            sel_reg      <= lzrd_pkg::SEL_RAM;
            wp_reg       <= lzrd_pkg::START_POS;
            fill_reg     <= '0;
            flags_reg    <= '0;
            rem_reg      <= 32'd1;
            sum_reg      <= '0;
            offlo_reg    <= '0;
            chk_reg      <= '0;
            chkcnt_reg   <= '0;
            len_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            sel_reg      <= sel_next;
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            flags_reg    <= flags_next;
            rem_reg      <= rem_next;
            sum_reg      <= sum_next;
            offlo_reg    <= offlo_next;
            chk_reg      <= chk_next;
            chkcnt_reg   <= chkcnt_next;
            len_reg      <= len_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lit_reg      <= lit_next;
        src_reg      <= src_next;
        fwd_byte_reg <= fwd_byte_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_isdata_reg <= m_isdata_next;
        m_last_reg   <= m_last_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        sel_next      = sel_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        flags_next    = flags_reg;
        rem_next      = rem_reg;
        sum_next      = sum_reg;
        offlo_next    = offlo_reg;
        chk_next      = chk_reg;
        chkcnt_next   = chkcnt_reg;
        lit_next      = lit_reg;
        src_next      = src_reg;
        len_next      = len_reg;
        fwd_byte_next = fwd_byte_reg;

        s_axis_tready = (state_reg == lzrd_pkg::S_IDLE);
        ram_re        = 1'b0;
        ram_raddr     = src_reg;
        do_byte       = 1'b0;
        do_status     = 1'b0;
        emit_last     = 1'b1;
        byte_val      = lit_reg;
        status_val    = lzrd_pkg::ST_RUN;

        unique case (state_reg)
            lzrd_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == lzrd_pkg::CMD_START)
                    begin
                        // restart stream; history reads as spaces again
                        wp_next     = lzrd_pkg::START_POS;
                        fill_next   = '0;
                        flags_next  = '0;
                        rem_next    = out_length_reg;
                        sum_next    = '0;
                        offlo_next  = '0;
                        chk_next    = '0;
                        chkcnt_next = '0;
                        phase_next  = (out_length_reg == 32'd0) ? lzrd_pkg::PH_CHECK
                                                                : lzrd_pkg::PH_FLAG;
                    end
                    else
                    begin
                        case (phase_reg) inside
                            lzrd_pkg::PH_FLAG:
                            begin
                                flags_next = {1'b1, s_axis_tdata};
                                phase_next = lzrd_pkg::PH_TOKEN;
                            end
                            lzrd_pkg::PH_TOKEN:
                            begin
                                if (flags_reg[0])
                                begin
                                    lit_next   = s_axis_tdata;
                                    state_next = lzrd_pkg::S_LIT;
                                end
                                else
                                begin
                                    offlo_next = s_axis_tdata;
                                    phase_next = lzrd_pkg::PH_MLO;
                                end
                            end
                            lzrd_pkg::PH_MLO, lzrd_pkg::PH_MHI:
                            begin
                                if ({27'd0, match_len} > rem_reg)
                                begin
                                    // overflow: report and stop
                                    lit_next   = {6'd0, lzrd_pkg::ST_OVERFLOW};
                                    phase_next = lzrd_pkg::PH_STOP;
                                    state_next = lzrd_pkg::S_LIT;
                                end
                                else
                                begin
                                    src_next   = src_first;
                                    len_next   = match_len;
                                    state_next = lzrd_pkg::S_RD;
                                end
                            end
                            lzrd_pkg::PH_CHECK:
                            begin
                                chk_next    = chk_upd;
                                chkcnt_next = chkcnt_inc;
                                if (chkcnt_inc == 2'd0)
                                begin
                                    lit_next   = {6'd0, (chk_upd == sum_reg)
                                                        ? lzrd_pkg::ST_OK
                                                        : lzrd_pkg::ST_MISMATCH};
                                    phase_next = lzrd_pkg::PH_STOP;
                                    state_next = lzrd_pkg::S_LIT;
                                end
                            end
                            default:
                            begin
                                // stopped: ignore bytes
                            end
                        endcase
                    end
                end
            end

            lzrd_pkg::S_LIT:
            begin
                // single word: literal byte, or a status once stopped
                if (slot_free)
                begin
                    state_next = lzrd_pkg::S_IDLE;
                    if (phase_reg == lzrd_pkg::PH_STOP)
                    begin
                        do_status  = 1'b1;
                        status_val = lit_reg[1:0];
                    end
                    else
                    begin
                        do_byte    = 1'b1;
                        flags_next = flags_shr;
                        phase_next = phase_after;
                    end
                end
            end

            lzrd_pkg::S_RD:
            begin
                // first read of a match, nothing written this cycle
                ram_re    = 1'b1;
                ram_raddr = src_reg;
                sel_next  = lzrd_pkg::entry_written(src_reg, fill_reg) ? lzrd_pkg::SEL_RAM
                                                                       : lzrd_pkg::SEL_SPACE;
                state_next = lzrd_pkg::S_CPY;
            end

            lzrd_pkg::S_CPY:
            begin
                // emit one copied byte, write it back and read the next one
                if (slot_free)
                begin
                    do_byte   = 1'b1;
                    byte_val  = copy_byte;
                    emit_last = (len_reg == 5'd1);
                    if (len_reg == 5'd1)
                    begin
                        flags_next = flags_shr;
                        phase_next = phase_after;
                        state_next = lzrd_pkg::S_IDLE;
                    end
                    else
                    begin
                        len_next      = len_reg - 5'd1;
                        src_next      = src_inc;
                        ram_re        = 1'b1;
                        ram_raddr     = src_inc;
                        fwd_byte_next = copy_byte;
                        if (src_inc == wp_reg)
                        begin
                            sel_next = lzrd_pkg::SEL_FWD;
                        end
                        else if (lzrd_pkg::entry_written(src_inc, fill_reg))
                        begin
                            sel_next = lzrd_pkg::SEL_RAM;
                        end
                        else
                        begin
                            sel_next = lzrd_pkg::SEL_SPACE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = lzrd_pkg::S_IDLE;
            end
        endcase

        // ring write and running totals for every output byte
        ram_we = do_byte;
        if (do_byte)
        begin
            wp_next  = wp_reg + AW'(1);
            rem_next = rem_dec;
            sum_next = sum_reg + {24'd0, byte_val};
            if (fill_reg != lzrd_pkg::FILL_FULL)
            begin
                fill_next = fill_reg + (AW+1)'(1);
            end
        end

        // output register
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_isdata_next = m_isdata_reg;
        m_last_next   = m_last_reg;
        if (do_byte || do_status)
        begin
            m_valid_next  = 1'b1;
            m_data_next   = do_byte ? byte_val : 8'd0;
            m_status_next = do_byte ? lzrd_pkg::ST_RUN : status_val;
            m_isdata_next = do_byte;
            m_last_next   = emit_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, m_status_reg, m_data_reg};
    assign m_axis_tuser  = m_isdata_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- sv/lzrd_ram.sv -----
// lzrd_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lzrd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
